// ----- hw/rtl/terr_sched_pkg.sv -----
// ----------------------------------------------------------------------------
// terr_sched_pkg
// Shared types and codes for the timed event and round-robin scheduler.
// ----------------------------------------------------------------------------
package terr_sched_pkg;

  localparam logic [2:0] REQ_SERVICE   = 3'd0;
  localparam logic [2:0] REQ_EV_CREATE = 3'd1;
  localparam logic [2:0] REQ_EV_REMOVE = 3'd2;
  localparam logic [2:0] REQ_TK_CREATE = 3'd3;
  localparam logic [2:0] REQ_TK_REMOVE = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NULL_TAG = 2'd2;
  localparam logic [1:0] ST_NO_ID    = 2'd3;

  localparam logic [1:0] GK_NONE  = 2'd0;
  localparam logic [1:0] GK_EVENT = 2'd1;
  localparam logic [1:0] GK_TASK  = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] timer_value;
    logic [31:0] interval_ticks;
    logic [1:0]  priority_req;
    logic [15:0] task_tag;
    logic [2:0]  slot_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  grant_kind;
    logic [15:0] granted_tag;
    logic [2:0]  result_slot;
  } rsp_t;

endpackage

// ----- hw/rtl/timed_event_and_round_robin_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// timed_event_and_round_robin_scheduler_unit
// Priority-ordered periodic event table plus a round-robin task list.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid_i/req_stall_o | terr_sched_pkg::req_t
// rsp     | out       | rsp_valid_o/rsp_stall_i | terr_sched_pkg::rsp_t
//
// One transaction at a time. After accept, a single walker over the tables
// steps through the entries (service, search, shift), up to the slot count.
// Reset clears counts, pointer and timer, and sets the identifier tables to
// their slot numbers; entry payloads are written before use. The request side
// stalls while a transaction is in work or while a response waits; the
// response holds under rsp_stall_i.
// ----------------------------------------------------------------------------
module timed_event_and_round_robin_scheduler_unit #(
  parameter int EVENT_SLOTS = 8,
  parameter int TASK_SLOTS  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_stall_o,
  input  terr_sched_pkg::req_t req_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_stall_i,
  output terr_sched_pkg::rsp_t rsp_o
);

  localparam int EW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int EC = $clog2(EVENT_SLOTS + 1);
  localparam int TC = $clog2(TASK_SLOTS + 1);
  localparam int PW = (TC > 4) ? TC : 4;
  localparam int IW = (EC > TC) ? EC : TC;

  typedef enum logic [2:0] {
    S_IDLE, S_SERV, S_ROBIN, S_EINS, S_ESRCH, S_ESHIFT, S_TSRCH, S_TSHIFT
  } state_e;

  state_e state_q;
  terr_sched_pkg::req_t req_q;

  // event table
  logic [15:0] ev_tag_q  [EVENT_SLOTS];
  logic [31:0] ev_int_q  [EVENT_SLOTS];
  logic [31:0] ev_cd_q   [EVENT_SLOTS];
  logic [1:0]  ev_pri_q  [EVENT_SLOTS];
  logic [2:0]  ev_id_q   [EVENT_SLOTS];
  logic [EC-1:0] ev_cnt_q;
  // task list
  logic [15:0] tk_tag_q  [TASK_SLOTS];
  logic [2:0]  tk_id_q   [TASK_SLOTS];
  logic [TC-1:0] tk_cnt_q;
  logic [PW-1:0] robin_q;
  logic [15:0] last_timer_q;

  // walker
  logic [IW-1:0] idx_q;     // shared index for all walks
  logic [15:0]   elapsed_q;
  logic          granted_q;
  logic [2:0]    hold_id_q; // identifier carried by insert / freed on remove

  logic          rsp_valid_q;
  terr_sched_pkg::rsp_t rsp_q;

  assign req_stall_o = (state_q != S_IDLE) || rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  wire accept = req_valid_i && !req_stall_o;

  // shared compare/subtract unit on the entry under the walker
  logic [EW-1:0] ei;
  logic [EW-1:0] eim1;
  logic [TW-1:0] ti;
  logic [31:0]   cd_cur;
  logic          cd_due;
  logic [31:0]   cd_sub;
  assign ei     = idx_q[EW-1:0];
  assign eim1   = EW'(idx_q - IW'(1));
  assign ti     = TW'(idx_q);
  assign cd_cur = ev_cd_q[ei];
  assign cd_due = cd_cur <= {16'd0, elapsed_q};
  assign cd_sub = cd_cur - {16'd0, elapsed_q};

  function automatic terr_sched_pkg::rsp_t mk(logic [1:0] st, logic [1:0] gk,
                                               logic [15:0] tg, logic [2:0] sl);
    terr_sched_pkg::rsp_t r;
    r.status = st; r.grant_kind = gk; r.granted_tag = tg; r.result_slot = sl;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ev_cnt_q     <= '0;
      tk_cnt_q     <= '0;
      robin_q      <= '0;
      last_timer_q <= '0;
      rsp_valid_q  <= 1'b0;
      idx_q        <= '0;
      granted_q    <= 1'b0;
      for (int k = 0; k < EVENT_SLOTS; k++) ev_id_q[k] <= 3'(k);
      for (int k = 0; k < TASK_SLOTS; k++) tk_id_q[k] <= 3'(k);
    end else begin
      if (rsp_valid_q && !rsp_stall_i) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q <= req_i;
            idx_q <= '0;
            unique case (req_i.req_type)
              terr_sched_pkg::REQ_SERVICE: begin
                elapsed_q    <= req_i.timer_value - last_timer_q;
                last_timer_q <= req_i.timer_value;
                granted_q    <= 1'b0;
                state_q      <= S_SERV;
              end
              terr_sched_pkg::REQ_EV_CREATE: begin
                if (req_i.task_tag == '0) begin
                  rsp_q <= mk(terr_sched_pkg::ST_NULL_TAG, '0, '0, '0);
                  rsp_valid_q <= 1'b1;
                end else if (ev_cnt_q >= EC'(EVENT_SLOTS)) begin
                  rsp_q <= mk(terr_sched_pkg::ST_FULL, '0, '0, '0);
                  rsp_valid_q <= 1'b1;
                end else begin
                  hold_id_q <= ev_id_q[EW'(ev_cnt_q)];
                  idx_q     <= IW'(ev_cnt_q);
                  ev_cnt_q  <= ev_cnt_q + EC'(1);
                  state_q   <= S_EINS;
                end
              end
              terr_sched_pkg::REQ_EV_REMOVE: state_q <= S_ESRCH;
              terr_sched_pkg::REQ_TK_CREATE: begin
                if (req_i.task_tag == '0) begin
                  rsp_q <= mk(terr_sched_pkg::ST_NULL_TAG, '0, '0, '0);
                end else if (tk_cnt_q >= TC'(TASK_SLOTS)) begin
                  rsp_q <= mk(terr_sched_pkg::ST_FULL, '0, '0, '0);
                end else begin
                  tk_tag_q[TW'(tk_cnt_q)] <= req_i.task_tag;
                  tk_cnt_q <= tk_cnt_q + TC'(1);
                  rsp_q <= mk(terr_sched_pkg::ST_OK, '0, req_i.task_tag,
                              tk_id_q[TW'(tk_cnt_q)]);
                end
                rsp_valid_q <= 1'b1;
              end
              terr_sched_pkg::REQ_TK_REMOVE: state_q <= S_TSRCH;
              default: begin
                rsp_q <= mk('0, '0, '0, '0);
                rsp_valid_q <= 1'b1;
              end
            endcase
          end
        end
        // one event per cycle through the countdown unit
        S_SERV: begin
          if (idx_q < IW'(ev_cnt_q)) begin
            if (cd_due) begin
              if (!granted_q) begin
                granted_q   <= 1'b1;
                ev_cd_q[ei] <= ev_int_q[ei];
                rsp_q <= mk(terr_sched_pkg::ST_OK, terr_sched_pkg::GK_EVENT,
                            ev_tag_q[ei], ev_id_q[ei]);
              end else begin
                ev_cd_q[ei] <= '0;
              end
            end else begin
              ev_cd_q[ei] <= cd_sub;
            end
            idx_q <= idx_q + IW'(1);
          end else if (granted_q) begin
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_ROBIN;
          end
        end
        S_ROBIN: begin
          if (robin_q < PW'(tk_cnt_q)) begin
            rsp_q <= mk(terr_sched_pkg::ST_OK, terr_sched_pkg::GK_TASK,
                        tk_tag_q[TW'(robin_q)], tk_id_q[TW'(robin_q)]);
            robin_q <= robin_q + PW'(1);
          end else begin
            rsp_q   <= mk('0, '0, '0, '0);
            robin_q <= '0;
          end
          rsp_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        // insertion sort step: move one larger-priority entry down a place, else write the new entry
        S_EINS: begin
          if (idx_q != '0 && ev_pri_q[eim1] > req_q.priority_req) begin
            ev_tag_q[ei] <= ev_tag_q[eim1];
            ev_int_q[ei] <= ev_int_q[eim1];
            ev_cd_q[ei]  <= ev_cd_q[eim1];
            ev_pri_q[ei] <= ev_pri_q[eim1];
            ev_id_q[ei]  <= ev_id_q[eim1];
            idx_q        <= idx_q - IW'(1);
          end else begin
            ev_tag_q[ei] <= req_q.task_tag;
            ev_int_q[ei] <= req_q.interval_ticks;
            ev_cd_q[ei]  <= '0;
            ev_pri_q[ei] <= req_q.priority_req;
            ev_id_q[ei]  <= hold_id_q;
            rsp_q <= mk(terr_sched_pkg::ST_OK, '0, req_q.task_tag, hold_id_q);
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_ESRCH: begin
          if (idx_q >= IW'(ev_cnt_q)) begin
            rsp_q <= mk(terr_sched_pkg::ST_NO_ID, '0, '0, req_q.slot_id);
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (ev_id_q[ei] == req_q.slot_id) begin
            hold_id_q <= ev_id_q[ei];
            state_q   <= S_ESHIFT;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_ESHIFT: begin
          if (idx_q + IW'(1) < IW'(ev_cnt_q)) begin
            ev_tag_q[ei] <= ev_tag_q[EW'(idx_q + IW'(1))];
            ev_int_q[ei] <= ev_int_q[EW'(idx_q + IW'(1))];
            ev_cd_q[ei]  <= ev_cd_q[EW'(idx_q + IW'(1))];
            ev_pri_q[ei] <= ev_pri_q[EW'(idx_q + IW'(1))];
            ev_id_q[ei]  <= ev_id_q[EW'(idx_q + IW'(1))];
            idx_q        <= idx_q + IW'(1);
          end else begin
            ev_id_q[ei] <= hold_id_q;
            ev_cnt_q    <= ev_cnt_q - EC'(1);
            rsp_q <= mk(terr_sched_pkg::ST_OK, '0, '0, req_q.slot_id);
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_TSRCH: begin
          if (idx_q >= IW'(tk_cnt_q) || idx_q >= IW'(TASK_SLOTS)) begin
            rsp_q <= mk(terr_sched_pkg::ST_NO_ID, '0, '0, req_q.slot_id);
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (tk_id_q[ti] == req_q.slot_id) begin
            hold_id_q <= tk_id_q[ti];
            state_q   <= S_TSHIFT;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_TSHIFT: begin
          if (idx_q + IW'(1) < IW'(tk_cnt_q)) begin
            tk_tag_q[ti] <= tk_tag_q[TW'(idx_q + IW'(1))];
            tk_id_q[ti]  <= tk_id_q[TW'(idx_q + IW'(1))];
            idx_q        <= idx_q + IW'(1);
          end else begin
            tk_id_q[ti] <= hold_id_q;
            tk_cnt_q    <= tk_cnt_q - TC'(1);
            rsp_q <= mk(terr_sched_pkg::ST_OK, '0, '0, req_q.slot_id);
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // table counts never exceed their capacity
  a_ev_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_cnt_q <= EC'(EVENT_SLOTS)) else $error("event count overflow");
  a_tk_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tk_cnt_q <= TC'(TASK_SLOTS)) else $error("task count overflow");
  // a waiting response blocks new transactions
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> req_stall_o) else $error("accept while response pending");
  // every accept leaves the idle state or produces a response
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE) || rsp_valid_q)
    else $error("transaction lost");

endmodule
